[design/ptproj_pkg.sv]
// package: constants, types and helper functions of the point projector
`default_nettype none

package ptproj_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam longint unsigned FX_ONE = 64'd1 << FRAC_BITS;

  localparam int unsigned NUM_COEF = 21;
  localparam int unsigned IDX_PR_BASE = 9;
  localparam int unsigned IDX_TX = 18;
  localparam int unsigned IDX_TY = 19;
  localparam int unsigned IDX_TZ = 20;

  localparam longint unsigned INV_PITCH_VAL = (FX_ONE * 64'd10000 + 64'd11) / 64'd23;
  localparam int unsigned INV_W = $clog2(INV_PITCH_VAL + 64'd1);
  localparam int unsigned NUM_W = ((32 + INV_W + 1) / 2) * 2;
  localparam int unsigned DIV_ST = NUM_W / 2;
  localparam int unsigned CLAMP_W = 32 + FRAC_BITS;
  localparam int unsigned FW = NUM_W + 2;
  localparam int unsigned HI_W = CLAMP_W - 24;
  localparam int unsigned PW = CLAMP_W + 26;

  localparam logic [INV_W-1:0] INV_PITCH = INV_W'(INV_PITCH_VAL);
  localparam logic signed [31:0] OFS_X = 32'((FX_ONE * 64'd18 + 64'd5) / 64'd10);
  localparam logic signed [31:0] OFS_Y = 32'((FX_ONE * 64'd24 + 64'd5) / 64'd10);
  localparam logic signed [63:0] DEPTH_BIAS = 64'(FX_ONE * 64'd10);
  localparam logic signed [CLAMP_W-1:0] CENTRE_I = CLAMP_W'(FX_ONE * 64'd319);
  localparam logic signed [CLAMP_W-1:0] CENTRE_J = CLAMP_W'(FX_ONE * 64'd239);
  localparam logic signed [CLAMP_W-1:0] CL_MAX = {1'b0, {(CLAMP_W-1){1'b1}}};
  localparam logic signed [CLAMP_W-1:0] CL_MIN = {1'b1, {(CLAMP_W-1){1'b0}}};
  localparam logic [23:0] SCALE_ONE = 24'(FX_ONE);

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_POINT = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_MODE   = 2'd0,
    CFG_XSCALE = 2'd1,
    CFG_YSCALE = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic        vis;
    logic        aneg_i;
    logic        aneg_j;
    logic        zero_i;
    logic        zero_j;
    logic        dneg;
    logic        dzero;
    logic [31:0] dm;
  } ctx_t;

  typedef struct packed {
    logic [31:0]      rem;
    logic [NUM_W-1:0] nq;
  } dstep_t;

  function automatic logic signed [31:0] sat32(input logic signed [127:0] x);
    logic signed [31:0] r;
    if (x > 128'sd2147483647) r = 32'sh7fffffff;
    else if (x < -128'sd2147483648) r = 32'sh80000000;
    else r = x[31:0];
    return r;
  endfunction

  // two restoring division steps
  function automatic dstep_t div_step2(input dstep_t s, input logic [31:0] dm);
    dstep_t r;
    logic [32:0] t;
    r = s;
    for (int b = 0; b < 2; b++) begin
      t = {r.rem, r.nq[NUM_W-1]};
      r.nq = {r.nq[NUM_W-2:0], 1'b0};
      if (t >= {1'b0, dm}) begin
        t = t - {1'b0, dm};
        r.nq[0] = 1'b1;
      end
      r.rem = t[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[design/pose_transform_point_projector_top.sv]
// top level: pipelined pose transform and perspective projection of points
//
// in_*  : one transaction per load or point; in_tuser is the command
//         (load one pose coefficient, or project one point)
// out_* : one transaction per projected point, none per load
// cfg_* : register writes (view mode, x and y view scale), only while idle
//
// a new transaction is taken every cycle while the output is not stalled;
// the pipeline holds a radix-4 divider of DIV_ST stages
// that divides by the depth. loads travel down the pipeline and update
// each stage's copy of the pose as they pass, so points keep program order.
// reset empties the pipeline and restores view mode 0 and unit view scales;
// pose coefficients are undefined until loaded.
// while a result waits with out_tready low the whole pipeline holds and
// in_tready drops; nothing is lost or repeated.
`default_nettype none

module pose_transform_point_projector_top (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // coef_index[4:0], coef_value[36:5], point_x[68:37], point_y[100:69],
  // point_z[132:101], zero fill
  input  wire logic [135:0] in_tdata,
  // command
  input  wire logic         in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // screen_i[31:0], screen_j[63:32]
  output logic [63:0]       out_tdata,
  // visible
  output logic              out_tuser,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [23:0]  cfg_wdata
);
  import ptproj_pkg::*;

  logic        adv;
  logic        in_acc;
  logic        mode_r;
  logic [23:0] xscale_r;
  logic [23:0] yscale_r;

  logic [4:0]         in_idx;
  logic signed [31:0] in_val;
  logic signed [31:0] in_p [3];

  // pose copies per stage
  logic signed [31:0] tr_r  [3];
  logic signed [31:0] yaw_r [9];
  logic signed [31:0] pr_r  [9];

  // stage 1
  logic               vld1_r, pt1_r;
  logic [4:0]         idx1_r;
  logic signed [31:0] val1_r;
  logic signed [31:0] v1_r [3];
  logic signed [31:0] v1_nxt [3];
  // stage 2
  logic               vld2_r, pt2_r;
  logic [4:0]         idx2_r;
  logic signed [31:0] val2_r;
  logic signed [31:0] v2_r [3];
  logic signed [47:0] py2_r [9];
  logic signed [47:0] py2_nxt [9];
  // stage 3
  logic               vld3_r, pt3_r;
  logic [4:0]         idx3_r;
  logic signed [31:0] val3_r;
  logic signed [31:0] w3_r [3];
  logic signed [31:0] w3_nxt [3];
  // stage 4
  logic               pt4_r;
  logic signed [47:0] pp4_r [9];
  logic signed [47:0] pp4_nxt [9];
  // stage 5
  logic               pt5_r;
  logic signed [31:0] f5_r [3];
  logic signed [31:0] f5_nxt [3];
  // stage 6
  logic               pt6_r;
  logic [31:0]        am_i6_r, am_j6_r;
  ctx_t               ctx6_r, ctx6_nxt;
  logic [31:0]        am_i6_nxt, am_j6_nxt;
  // stage 7
  logic               pt7_r;
  logic [NUM_W-1:0]   n_i7_r, n_j7_r;
  ctx_t               ctx7_r;
  // divider
  logic               dvld_r [DIV_ST];
  ctx_t               dctx_r [DIV_ST];
  dstep_t             di_r [DIV_ST];
  dstep_t             dj_r [DIV_ST];
  dstep_t             di_nxt [DIV_ST];
  dstep_t             dj_nxt [DIV_ST];
  // fold and clamp
  logic                      ptf_r, visf_r;
  logic signed [CLAMP_W-1:0] ff_i_r, ff_j_r, ff_i_nxt, ff_j_nxt;
  // scale products
  logic                      ptm_r, vism_r;
  logic signed [HI_W+24:0]   pa_i_r, pa_j_r;
  logic [47:0]               pb_i_r, pb_j_r;
  // output register
  logic               out_tvalid_r, out_tuser_r;
  logic [63:0]        out_tdata_r;
  logic signed [31:0] si_nxt, sj_nxt;

  assign adv       = !out_tvalid_r || out_tready;
  assign in_tready = adv;
  assign in_acc    = in_tvalid && adv;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  assign in_idx  = in_tdata[4:0];
  assign in_val  = in_tdata[36:5];
  assign in_p[0] = in_tdata[68:37];
  assign in_p[1] = in_tdata[100:69];
  assign in_p[2] = in_tdata[132:101];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      xscale_r <= SCALE_ONE;
      yscale_r <= SCALE_ONE;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MODE:   mode_r   <= cfg_wdata[0];
        CFG_XSCALE: xscale_r <= cfg_wdata;
        CFG_YSCALE: yscale_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // translation copy, written as loads are taken
  always_ff @(posedge clk) begin
    if (in_acc && cmd_t'(in_tuser) == CMD_LOAD && in_idx inside {[IDX_TX:IDX_TZ]}) begin
      tr_r[2'(in_idx - 5'(IDX_TX))] <= in_val;
    end
  end

  always_comb begin
    if (mode_r) begin
      v1_nxt[0] = sat32(-128'(in_p[0]));
      v1_nxt[2] = sat32(-128'(in_p[2]));
    end else begin
      v1_nxt[0] = sat32(128'(tr_r[0]) - 128'(in_p[0]));
      v1_nxt[2] = sat32(128'(tr_r[2]) - 128'(in_p[2]));
    end
    v1_nxt[1] = sat32(128'(tr_r[1]) - 128'(in_p[1]));
  end

  always_comb begin
    logic signed [63:0] m;
    for (int k = 0; k < 9; k++) begin
      m = yaw_r[k] * v1_r[k % 3];
      py2_nxt[k] = m[63:FRAC_BITS];
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      if (mode_r) begin
        w3_nxt[r] = v2_r[r];
      end else begin
        w3_nxt[r] = sat32(128'(py2_r[3*r]) + 128'(py2_r[3*r+1]) + 128'(py2_r[3*r+2]));
      end
    end
  end

  always_comb begin
    logic signed [63:0] m;
    for (int k = 0; k < 9; k++) begin
      m = pr_r[k] * w3_r[k % 3];
      pp4_nxt[k] = m[63:FRAC_BITS];
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      f5_nxt[r] = sat32(128'(pp4_r[3*r]) + 128'(pp4_r[3*r+1]) + 128'(pp4_r[3*r+2]));
    end
  end

  always_comb begin
    logic signed [31:0] ai, aj;
    logic signed [63:0] d;
    ai = sat32(128'(f5_r[0]) - 128'(OFS_X));
    aj = sat32(-128'(f5_r[1]) - 128'(OFS_Y));
    d  = -64'(f5_r[2]) - DEPTH_BIAS;
    ctx6_nxt.vis    = mode_r || !f5_r[2][31];
    ctx6_nxt.aneg_i = ai[31];
    ctx6_nxt.aneg_j = aj[31];
    ctx6_nxt.zero_i = ai == 32'sd0;
    ctx6_nxt.zero_j = aj == 32'sd0;
    ctx6_nxt.dneg   = d[63];
    ctx6_nxt.dzero  = d == 64'sd0;
    ctx6_nxt.dm     = 32'(d[63] ? -d : d);
    am_i6_nxt = 32'(ai[31] ? -(33'(ai)) : 33'(ai));
    am_j6_nxt = 32'(aj[31] ? -(33'(aj)) : 33'(aj));
  end

  always_comb begin
    for (int k = 0; k < DIV_ST; k++) begin
      if (k == 0) begin
        di_nxt[k] = div_step2('{rem: 32'd0, nq: n_i7_r}, ctx7_r.dm);
        dj_nxt[k] = div_step2('{rem: 32'd0, nq: n_j7_r}, ctx7_r.dm);
      end else begin
        di_nxt[k] = div_step2(di_r[k-1], dctx_r[k-1].dm);
        dj_nxt[k] = div_step2(dj_r[k-1], dctx_r[k-1].dm);
      end
    end
  end

  always_comb begin
    ctx_t               c;
    logic signed [FW-1:0] fi, fj;
    c  = dctx_r[DIV_ST-1];
    fi = (c.aneg_i ^ c.dneg) ? -(FW'(di_r[DIV_ST-1].nq)) : FW'(di_r[DIV_ST-1].nq);
    fj = (c.aneg_j ^ c.dneg) ? -(FW'(dj_r[DIV_ST-1].nq)) : FW'(dj_r[DIV_ST-1].nq);
    fi = fi + FW'(CENTRE_I);
    fj = fj + FW'(CENTRE_J);
    if (fi > FW'(CL_MAX)) ff_i_nxt = CL_MAX;
    else if (fi < FW'(CL_MIN)) ff_i_nxt = CL_MIN;
    else ff_i_nxt = fi[CLAMP_W-1:0];
    if (fj > FW'(CL_MAX)) ff_j_nxt = CL_MAX;
    else if (fj < FW'(CL_MIN)) ff_j_nxt = CL_MIN;
    else ff_j_nxt = fj[CLAMP_W-1:0];
    // zero depth: quotient is huge with the numerator sign, or the centre for a zero numerator
    if (c.dzero) begin
      ff_i_nxt = c.zero_i ? CENTRE_I : (c.aneg_i ? CL_MIN : CL_MAX);
      ff_j_nxt = c.zero_j ? CENTRE_J : (c.aneg_j ? CL_MIN : CL_MAX);
    end
  end

  always_comb begin
    logic signed [PW-1:0] pi, pj;
    pi = (PW'(pa_i_r) <<< 24) + $signed(PW'(pb_i_r));
    pj = (PW'(pa_j_r) <<< 24) + $signed(PW'(pb_j_r));
    si_nxt = sat32(128'(pi >>> FRAC_BITS));
    sj_nxt = sat32(128'(pj >>> FRAC_BITS));
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0; vld2_r <= 1'b0; vld3_r <= 1'b0;
      pt1_r <= 1'b0; pt2_r <= 1'b0; pt3_r <= 1'b0; pt4_r <= 1'b0;
      pt5_r <= 1'b0; pt6_r <= 1'b0; pt7_r <= 1'b0;
      ptf_r <= 1'b0; ptm_r <= 1'b0; out_tvalid_r <= 1'b0;
      for (int k = 0; k < DIV_ST; k++) dvld_r[k] <= 1'b0;
    end else if (adv) begin
      vld1_r <= in_tvalid;
      pt1_r  <= in_tvalid && cmd_t'(in_tuser) == CMD_POINT;
      vld2_r <= vld1_r; pt2_r <= pt1_r;
      vld3_r <= vld2_r; pt3_r <= pt2_r;
      pt4_r <= pt3_r; pt5_r <= pt4_r; pt6_r <= pt5_r; pt7_r <= pt6_r;
      dvld_r[0] <= pt7_r;
      for (int k = 1; k < DIV_ST; k++) dvld_r[k] <= dvld_r[k-1];
      ptf_r <= dvld_r[DIV_ST-1];
      ptm_r <= ptf_r;
      out_tvalid_r <= ptm_r;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (adv) begin
      idx1_r <= in_idx; val1_r <= in_val; v1_r <= v1_nxt;
      if (vld1_r && !pt1_r && idx1_r < 5'(IDX_PR_BASE)) yaw_r[4'(idx1_r)] <= val1_r;
      idx2_r <= idx1_r; val2_r <= val1_r; v2_r <= v1_r; py2_r <= py2_nxt;
      idx3_r <= idx2_r; val3_r <= val2_r; w3_r <= w3_nxt;
      if (vld3_r && !pt3_r && idx3_r inside {[IDX_PR_BASE:IDX_TX-1]}) begin
        pr_r[4'(idx3_r - 5'(IDX_PR_BASE))] <= val3_r;
      end
      pp4_r <= pp4_nxt;
      f5_r <= f5_nxt;
      ctx6_r <= ctx6_nxt; am_i6_r <= am_i6_nxt; am_j6_r <= am_j6_nxt;
      ctx7_r <= ctx6_r;
      n_i7_r <= NUM_W'(am_i6_r) * NUM_W'(INV_PITCH);
      n_j7_r <= NUM_W'(am_j6_r) * NUM_W'(INV_PITCH);
      dctx_r[0] <= ctx7_r;
      for (int k = 1; k < DIV_ST; k++) dctx_r[k] <= dctx_r[k-1];
      di_r <= di_nxt; dj_r <= dj_nxt;
      visf_r <= dctx_r[DIV_ST-1].vis;
      ff_i_r <= ff_i_nxt; ff_j_r <= ff_j_nxt;
      vism_r <= visf_r;
      pa_i_r <= $signed(ff_i_r[CLAMP_W-1:24]) * $signed({1'b0, xscale_r});
      pa_j_r <= $signed(ff_j_r[CLAMP_W-1:24]) * $signed({1'b0, yscale_r});
      pb_i_r <= ff_i_r[23:0] * xscale_r;
      pb_j_r <= ff_j_r[23:0] * yscale_r;
      out_tuser_r <= vism_r;
      out_tdata_r <= vism_r ? {sj_nxt, si_nxt} : 64'd0;
    end
  end

`ifndef SYNTHESIS
  a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == 64'd0)
    else $error("hidden point carries non-zero coordinates");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result transaction straight after reset");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while pipeline is stalled");
`endif

endmodule

`default_nettype wire
